// ----- rtl/mie_pkg.sv -----
`timescale 1ns / 1ps

package mie_pkg;

    // width of every payload field on the ports
    localparam int FIELD_W = 64;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_FINAL  = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic finish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic loop_run;
    } stat_t;

endpackage

// ----- rtl/mie_dpath.sv -----
`timescale 1ns / 1ps

module mie_dpath #(
    parameter int WIDTH = 64
) (
    input  logic                          clk,
    input  logic [mie_pkg::FIELD_W-1:0]   value,
    input  logic [mie_pkg::FIELD_W-1:0]   modulus,
    input  mie_pkg::cmd_t                 cmd,
    output mie_pkg::stat_t                stat,
    output logic [mie_pkg::FIELD_W-1:0]   inverse
);
    import mie_pkg::*;

    // euclid pair, original modulus and bezout coefficients
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] b0_reg, b0_next;
    logic             x0_neg_reg, x0_neg_next;
    logic [WIDTH-1:0] x0_mag_reg, x0_mag_next;
    logic             x1_neg_reg, x1_neg_next;
    logic [WIDTH-1:0] x1_mag_reg, x1_mag_next;
    // divider remainder, quotient shifter and running quotient product
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] prod_reg, prod_next;
    logic [WIDTH-1:0] inv_reg, inv_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             qbit;
    logic             t_neg;
    logic             nx_neg;
    logic [WIDTH-1:0] nx_mag;
    logic [WIDTH:0]   twice_b0;
    logic [WIDTH-1:0] fin;

    // loop condition: dividend above one and divisor nonzero
    assign stat.loop_run = (a_reg > WIDTH'(1)) && (b_reg != '0);

    // one restoring division step, quotient bits msb first
    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        diff    = shifted - {1'b0, b_reg};
        qbit    = ~diff[WIDTH];
    end

    // signed add of x1 and the negated product q*x0
    always_comb
    begin
        t_neg = (prod_reg != '0) ? ~x0_neg_reg : 1'b0;
        if (x1_neg_reg == t_neg)
        begin
            nx_neg = x1_neg_reg;
            nx_mag = x1_mag_reg + prod_reg;
        end
        else if (x1_mag_reg >= prod_reg)
        begin
            nx_neg = x1_neg_reg;
            nx_mag = x1_mag_reg - prod_reg;
        end
        else
        begin
            nx_neg = t_neg;
            nx_mag = prod_reg - x1_mag_reg;
        end
        if (nx_mag == '0)
        begin
            nx_neg = 1'b0;
        end
    end

    // range correction of the final coefficient
    always_comb
    begin
        twice_b0 = {1'b0, b0_reg} + {1'b0, b0_reg};
        fin      = x1_mag_reg;
        if (b0_reg == WIDTH'(1))
        begin
            fin = WIDTH'(1);
        end
        else if (x1_neg_reg && (x1_mag_reg > b0_reg))
        begin
            fin = WIDTH'(twice_b0 - {1'b0, x1_mag_reg});
        end
        else
        begin
            if (x1_neg_reg)
            begin
                fin = b0_reg - x1_mag_reg;
            end
            if (fin == '0)
            begin
                fin = b0_reg;
            end
        end
    end

    // next state of the datapath registers
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        b0_next     = b0_reg;
        x0_neg_next = x0_neg_reg;
        x0_mag_next = x0_mag_reg;
        x1_neg_next = x1_neg_reg;
        x1_mag_next = x1_mag_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        prod_next   = prod_reg;
        inv_next    = inv_reg;
        if (cmd.load)
        begin
            a_next      = value[WIDTH-1:0];
            b_next      = modulus[WIDTH-1:0];
            b0_next     = modulus[WIDTH-1:0];
            x0_neg_next = 1'b0;
            x0_mag_next = '0;
            x1_neg_next = 1'b0;
            x1_mag_next = WIDTH'(1);
        end
        if (cmd.div_init)
        begin
            rem_next  = '0;
            quo_next  = a_reg;
            prod_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_next  = {quo_reg[WIDTH-2:0], qbit};
            prod_next = {prod_reg[WIDTH-2:0], 1'b0} + (qbit ? x0_mag_reg : '0);
        end
        if (cmd.update)
        begin
            a_next      = b_reg;
            b_next      = rem_reg;
            x1_neg_next = x0_neg_reg;
            x1_mag_next = x0_mag_reg;
            x0_neg_next = nx_neg;
            x0_mag_next = nx_mag;
        end
        if (cmd.finish)
        begin
            inv_next = fin;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        b0_reg     <= b0_next;
        x0_neg_reg <= x0_neg_next;
        x0_mag_reg <= x0_mag_next;
        x1_neg_reg <= x1_neg_next;
        x1_mag_reg <= x1_mag_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        prod_reg   <= prod_next;
        inv_reg    <= inv_next;
    end

    assign inverse = FIELD_W'(inv_reg);

endmodule

// ----- rtl/mie_ctrl.sv -----
`timescale 1ns / 1ps

module mie_ctrl #(
    parameter int WIDTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  mie_pkg::stat_t  stat,
    output mie_pkg::cmd_t   cmd
);
    import mie_pkg::*;

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;

    // sequencer: load, check, divide bit by bit, update, repeat; final step when the loop ends
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = '0;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.loop_run)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // accepted beat always starts with a loop check
    a_load_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_CHECK)
        else $error("load not followed by check");

    // divide counter idles at zero outside the divide phase
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DIV |-> cnt_reg == '0)
        else $error("divide counter not idle");

    // update only follows the last divide step
    a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> $past(state_reg) == ST_DIV)
        else $error("update without divide");

    // a result appears only when the final step ran
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINAL)
        else $error("output without final step");

endmodule

// ----- rtl/modular_inverse_egcd.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake             fields
// in       input      in_valid / in_stall   value[63:0], modulus[63:0]
// out      output     out_valid / out_stall inverse[63:0]
//
// one item at a time; each euclid iteration runs a loop check, WIDTH
// restoring divide steps accumulating the quotient product, and one
// coefficient update; each item adds a load, a last check and a final step
// reset (rst_n low) clears the controller and drops out_valid
// in_stall is high from the accepted beat until the result is registered
// a stalled result waits in the output register; a new item runs meanwhile

module modular_inverse_egcd #(
    parameter int WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mie_pkg::FIELD_W-1:0]  value,
    input  logic [mie_pkg::FIELD_W-1:0]  modulus,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mie_pkg::FIELD_W-1:0]  inverse
);
    import mie_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mie_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mie_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .clk     (clk),
        .value   (value),
        .modulus (modulus),
        .cmd     (cmd),
        .stat    (stat),
        .inverse (inverse)
    );

endmodule
